### sv/lbfit_pkg.sv
`default_nettype none

package lbfit_pkg;

  // Pixel dimension width; every coordinate and size field uses it.
  localparam int DIM_BITS = 16;
  localparam int PROD_BITS = 2 * DIM_BITS;
  localparam int TOL_BITS = 8;

  // Configuration port geometry.
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_IDX_BITS = CFG_ADDR_BITS - 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = CFG_IDX_BITS'(0);

  // Pipeline layout: input register, product stage, divider setup stage,
  // one stage per quotient bit, then the placement stage that drives out_data.
  localparam int DIV_STEPS = DIM_BITS;
  localparam int ST_IN = 0;
  localparam int ST_MUL = 1;
  localparam int ST_DIV0 = 2;
  localparam int ST_OUT = ST_DIV0 + DIV_STEPS + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef logic [DIM_BITS-1:0] dim_t;

  typedef struct packed {
    dim_t target_width;
    dim_t target_height;
    dim_t remote_width;
    dim_t remote_height;
    dim_t pub_x;
    dim_t pub_y;
    dim_t pub_width;
    dim_t pub_height;
    dim_t pub_remote_width;
    dim_t pub_remote_height;
  } in_beat_t;

  typedef struct packed {
    dim_t content_x;
    dim_t content_y;
    dim_t content_width;
    dim_t content_height;
    logic geometry_valid;
    logic used_published;
  } out_beat_t;

  // Product stage payload: sizes and the decisions made from the raw request.
  typedef struct packed {
    dim_t tw;
    dim_t th;
    dim_t rw;
    dim_t rh;
    dim_t px;
    dim_t py;
    dim_t pw;
    dim_t ph;
    logic zero;
    logic one_to_one;
    logic pub;
  } pre_t;

  // Payload carried alongside the divider.
  typedef struct packed {
    dim_t tw;
    dim_t th;
    dim_t w;
    dim_t h;
    dim_t x;
    dim_t y;
    logic valid;
    logic pub;
    logic fit;
    logic fill_width;
  } side_t;

endpackage

`default_nettype wire

### sv/letterbox_fit_geometry.sv
// Letterbox fit geometry engine.
//
// Each input beat on in_data carries a target surface size, a remote frame
// size and an optional published placement rectangle. For every accepted
// input beat exactly one output beat appears on out_data with the content
// rectangle, in the same order. A beat moves on a channel at a rising edge
// where its valid is high and its stall is low.
//
// The block is a 20-stage pipeline: an input register, a stage forming the
// two cross products, a stage picking the limiting axis, sixteen restoring
// divider stages that each resolve one quotient bit, and a placement stage
// that clamps, centers and drives the output register. A beat accepted at
// one edge passes through these stages in order before it is offered on
// out_valid; one beat can enter every cycle while in_stall is low.
//
// When the receiver holds out_stall, empty stages still fill, so the block
// keeps taking input beats until every stage holds one; only then does
// in_stall rise. Synchronous reset (rst_n low) empties the pipeline and
// clears one_to_one_tolerance to zero. The tolerance register sits at APB
// byte address 0 and should only be written while the pipeline is empty.
`default_nettype none

module letterbox_fit_geometry (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [lbfit_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [lbfit_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [lbfit_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                    pready,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  lbfit_pkg::in_beat_t                     in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output lbfit_pkg::out_beat_t                    out_data
);

  localparam int DW = lbfit_pkg::DIM_BITS;
  localparam int PW = lbfit_pkg::PROD_BITS;
  localparam int TW = lbfit_pkg::TOL_BITS;
  localparam int NS = lbfit_pkg::NUM_STAGES;
  localparam int DS = lbfit_pkg::DIV_STEPS;

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  logic [TW-1:0] tol_r;
  logic [TW-1:0] tol_nxt;
  logic          reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[lbfit_pkg::CFG_ADDR_BITS-1:2] == lbfit_pkg::REG_TOLERANCE);

  always_comb begin
    tol_nxt = tol_r;
    if (psel && penable && pwrite && reg_hit) begin
      tol_nxt = pwdata[TW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(lbfit_pkg::CFG_DATA_BITS-TW){1'b0}}, tol_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. A stage may load when it or any stage after it
  // is empty, or when the output is not stalled, so bubbles collapse.
  // ---------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;

  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !out_stall || !(&vld_r[NS-1:k]);
  end

  always_comb begin
    vld_nxt[lbfit_pkg::ST_IN] = adv[lbfit_pkg::ST_IN] ? in_valid : vld_r[lbfit_pkg::ST_IN];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[lbfit_pkg::ST_IN];
  assign out_valid = vld_r[lbfit_pkg::ST_OUT];

  // ---------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------
  lbfit_pkg::in_beat_t inb_r;

  always_ff @(posedge clk) begin
    if (adv[lbfit_pkg::ST_IN]) begin
      inb_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Product stage: cross products, zero check, 1:1 check, published check.
  // ---------------------------------------------------------------------
  lbfit_pkg::pre_t pre_nxt;
  lbfit_pkg::pre_t pre_r;
  logic [PW-1:0]   pa_nxt;
  logic [PW-1:0]   pb_nxt;
  logic [PW-1:0]   pa_r;
  logic [PW-1:0]   pb_r;
  logic [DW:0]     pub_right;
  logic [DW:0]     pub_bottom;
  logic [DW-1:0]   tol_ext;

  assign tol_ext    = {{(DW-TW){1'b0}}, tol_r};
  assign pub_right  = {1'b0, inb_r.pub_x} + {1'b0, inb_r.pub_width};
  assign pub_bottom = {1'b0, inb_r.pub_y} + {1'b0, inb_r.pub_height};
  assign pa_nxt     = {{DW{1'b0}}, inb_r.target_width} * {{DW{1'b0}}, inb_r.remote_height};
  assign pb_nxt     = {{DW{1'b0}}, inb_r.target_height} * {{DW{1'b0}}, inb_r.remote_width};

  always_comb begin
    pre_nxt.tw   = inb_r.target_width;
    pre_nxt.th   = inb_r.target_height;
    pre_nxt.rw   = inb_r.remote_width;
    pre_nxt.rh   = inb_r.remote_height;
    pre_nxt.px   = inb_r.pub_x;
    pre_nxt.py   = inb_r.pub_y;
    pre_nxt.pw   = inb_r.pub_width;
    pre_nxt.ph   = inb_r.pub_height;
    pre_nxt.zero = (inb_r.target_width == '0) || (inb_r.target_height == '0) ||
                   (inb_r.remote_width == '0) || (inb_r.remote_height == '0);
    pre_nxt.one_to_one = (inb_r.remote_width <= inb_r.target_width) &&
                         (inb_r.remote_height <= inb_r.target_height) &&
                         ((inb_r.target_width - inb_r.remote_width) <= tol_ext) &&
                         ((inb_r.target_height - inb_r.remote_height) <= tol_ext);
    pre_nxt.pub  = !pre_nxt.zero &&
                   (inb_r.pub_width != '0) && (inb_r.pub_height != '0) &&
                   (inb_r.pub_remote_width == inb_r.remote_width) &&
                   (inb_r.pub_remote_height == inb_r.remote_height) &&
                   (inb_r.pub_x < inb_r.target_width) &&
                   (inb_r.pub_y < inb_r.target_height) &&
                   (pub_right <= {1'b0, inb_r.target_width}) &&
                   (pub_bottom <= {1'b0, inb_r.target_height});
  end

  always_ff @(posedge clk) begin
    if (adv[lbfit_pkg::ST_MUL]) begin
      pre_r <= pre_nxt;
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Divider setup: the smaller cross product picks the axis that fills the
  // target, and the other axis is that product over the remote size.
  // Index 0 of the divider arrays holds the setup stage.
  // ---------------------------------------------------------------------
  lbfit_pkg::side_t side_r [0:DS];
  logic [DW-1:0]    rem_r  [0:DS];
  logic [DW-1:0]    low_r  [0:DS];
  logic [DW-1:0]    dsr_r  [0:DS];
  lbfit_pkg::side_t side0_nxt;
  logic [PW-1:0]    dvd_nxt;
  logic [DW-1:0]    dsr0_nxt;
  logic             fill_w;

  assign fill_w   = (pa_r <= pb_r);
  assign dvd_nxt  = fill_w ? pa_r : pb_r;
  assign dsr0_nxt = fill_w ? pre_r.rw : pre_r.rh;

  always_comb begin
    side0_nxt.tw         = pre_r.tw;
    side0_nxt.th         = pre_r.th;
    side0_nxt.x          = pre_r.px;
    side0_nxt.y          = pre_r.py;
    side0_nxt.valid      = !pre_r.zero;
    side0_nxt.pub        = pre_r.pub;
    side0_nxt.fit        = !pre_r.pub && !pre_r.one_to_one;
    side0_nxt.fill_width = fill_w;
    if (pre_r.pub) begin
      side0_nxt.w = pre_r.pw;
      side0_nxt.h = pre_r.ph;
    end else if (pre_r.one_to_one) begin
      side0_nxt.w = pre_r.rw;
      side0_nxt.h = pre_r.rh;
    end else begin
      side0_nxt.w = pre_r.tw;
      side0_nxt.h = pre_r.th;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[lbfit_pkg::ST_DIV0]) begin
      side_r[0] <= side0_nxt;
      rem_r[0]  <= dvd_nxt[PW-1:DW];
      low_r[0]  <= dvd_nxt[DW-1:0];
      dsr_r[0]  <= dsr0_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage. The quotient never
  // exceeds the target size, so the upper dividend half starts below the
  // divisor. Dividend bits leave the top of low_r as quotient bits enter
  // at the bottom.
  // ---------------------------------------------------------------------
  logic [DW-1:0] rem_nxt [1:DS];
  logic [DW-1:0] low_nxt [1:DS];

  for (genvar j = 1; j <= DS; j++) begin : g_div
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial      = {rem_r[j-1], low_r[j-1][DW-1]};
    assign diff       = trial - {1'b0, dsr_r[j-1]};
    assign ge         = (trial >= {1'b0, dsr_r[j-1]});
    assign rem_nxt[j] = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign low_nxt[j] = {low_r[j-1][DW-2:0], ge};

    always_ff @(posedge clk) begin
      if (adv[lbfit_pkg::ST_DIV0 + j]) begin
        rem_r[j]  <= rem_nxt[j];
        low_r[j]  <= low_nxt[j];
        dsr_r[j]  <= dsr_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Placement stage: clamp the derived axis to [1, target], center the
  // unscaled or fitted rectangle, or pass the published rectangle through.
  // ---------------------------------------------------------------------
  lbfit_pkg::side_t     fin_side;
  logic [DW-1:0]        fin_q;
  logic [DW-1:0]        fin_qc;
  logic [DW-1:0]        fin_w;
  logic [DW-1:0]        fin_h;
  lbfit_pkg::out_beat_t out_nxt;
  lbfit_pkg::out_beat_t out_r;

  assign fin_side = side_r[DS];
  assign fin_q    = low_r[DS];
  assign fin_qc   = (fin_q == '0) ? DW'(1) : fin_q;

  always_comb begin
    fin_w = fin_side.w;
    fin_h = fin_side.h;
    if (fin_side.fit) begin
      if (fin_side.fill_width) begin
        fin_h = (fin_qc > fin_side.th) ? fin_side.th : fin_qc;
      end else begin
        fin_w = (fin_qc > fin_side.tw) ? fin_side.tw : fin_qc;
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    if (fin_side.valid) begin
      out_nxt.content_width  = fin_w;
      out_nxt.content_height = fin_h;
      out_nxt.geometry_valid = 1'b1;
      out_nxt.used_published = fin_side.pub;
      if (fin_side.pub) begin
        out_nxt.content_x = fin_side.x;
        out_nxt.content_y = fin_side.y;
      end else begin
        out_nxt.content_x = (fin_side.tw - fin_w) >> 1;
        out_nxt.content_y = (fin_side.th - fin_h) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[lbfit_pkg::ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.geometry_valid |->
      out_data.content_x == '0 && out_data.content_y == '0 &&
      out_data.content_width == '0 && out_data.content_height == '0 &&
      !out_data.used_published)
    else $error("invalid geometry beat carries a nonzero field");

  a_pub_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.used_published |-> out_data.geometry_valid)
    else $error("published rectangle taken without valid geometry");

  a_fit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.geometry_valid |->
      out_data.content_width != '0 && out_data.content_height != '0)
    else $error("valid geometry with an empty rectangle");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without downstream backpressure");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[lbfit_pkg::ST_OUT-1] && side_r[DS].valid && side_r[DS].fit |->
      rem_r[DS] < dsr_r[DS])
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

// Testbench for letterbox_fit_geometry: placement of a remote frame on a
// display surface. Every request beat yields one rectangle beat. This bench
// computes each rectangle itself when a request is accepted and compares the
// rectangles from the block, in order and field by field.
module tb;

  // Index with no register behind it; the only register is REG_TOLERANCE.
  localparam logic [lbfit_pkg::CFG_IDX_BITS-1:0] REG_SPARE = lbfit_pkg::CFG_IDX_BITS'(1);

  logic                                clk;
  logic                                rst_n;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [lbfit_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [lbfit_pkg::CFG_DATA_BITS-1:0] pwdata;
  logic [lbfit_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                                pready;
  logic                                in_valid;
  logic                                in_stall;
  lbfit_pkg::in_beat_t                 in_data;
  logic                                out_valid;
  logic                                out_stall;
  lbfit_pkg::out_beat_t                out_data;

  // Rectangles still owed by the block, oldest first.
  lbfit_pkg::out_beat_t           expected_rects[$];
  // This bench's copy of one_to_one_tolerance, updated when a write lands.
  logic [lbfit_pkg::TOL_BITS-1:0] tolerance_now = '0;
  bit                             failed        = 1'b0;

  // Idle knobs in percent per cycle, and the long receiver hold-off counter.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_off_left = 0;

  letterbox_fit_geometry i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The timeout here leaves a wide margin for a slow block.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Computes the rectangle the block must produce for one request under the
  // given tolerance. All arithmetic is done at 64 bits, so the cross products
  // and the published edge sums never wrap.
  function automatic lbfit_pkg::out_beat_t fit_content_rect(
    lbfit_pkg::in_beat_t req, logic [lbfit_pkg::TOL_BITS-1:0] tol);
    logic [63:0]          tw, th, rw, rh, px, py, pw, ph, prw, prh;
    logic [63:0]          cross_w, cross_h, cw, ch;
    lbfit_pkg::out_beat_t rect;
    tw   = 64'(req.target_width);
    th   = 64'(req.target_height);
    rw   = 64'(req.remote_width);
    rh   = 64'(req.remote_height);
    px   = 64'(req.pub_x);
    py   = 64'(req.pub_y);
    pw   = 64'(req.pub_width);
    ph   = 64'(req.pub_height);
    prw  = 64'(req.pub_remote_width);
    prh  = 64'(req.pub_remote_height);
    rect = '0;
    if (tw != 0 && th != 0 && rw != 0 && rh != 0) begin
      if (rw <= tw && rh <= th && tw - rw <= 64'(tol) && th - rh <= 64'(tol)) begin
        cw = rw;
        ch = rh;
      end else begin
        // The smaller cross product names the axis that the frame fills.
        cross_w = tw * rh;
        cross_h = th * rw;
        if (cross_w <= cross_h) begin
          cw = tw;
          ch = cross_w / rw;
          if (ch < 1) ch = 1;
        end else begin
          ch = th;
          cw = cross_h / rh;
          if (cw < 1) cw = 1;
        end
      end
      if (cw > tw) cw = tw;
      if (ch > th) ch = th;
      rect.content_x      = lbfit_pkg::dim_t'((tw - cw) >> 1);
      rect.content_y      = lbfit_pkg::dim_t'((th - ch) >> 1);
      rect.content_width  = lbfit_pkg::dim_t'(cw);
      rect.content_height = lbfit_pkg::dim_t'(ch);
      rect.geometry_valid = (cw != 0 && ch != 0);
      if (rect.geometry_valid && pw != 0 && ph != 0 && prw == rw && prh == rh &&
          px < tw && py < th && px + pw <= tw && py + ph <= th) begin
        rect.used_published = 1'b1;
        rect.content_x      = req.pub_x;
        rect.content_y      = req.pub_y;
        rect.content_width  = req.pub_width;
        rect.content_height = req.pub_height;
      end
    end
    return rect;
  endfunction

  function automatic lbfit_pkg::in_beat_t make_request(int tw, int th, int rw, int rh,
                                                       int px, int py, int pw, int ph,
                                                       int prw, int prh);
    lbfit_pkg::in_beat_t req;
    req.target_width      = lbfit_pkg::dim_t'(tw);
    req.target_height     = lbfit_pkg::dim_t'(th);
    req.remote_width      = lbfit_pkg::dim_t'(rw);
    req.remote_height     = lbfit_pkg::dim_t'(rh);
    req.pub_x             = lbfit_pkg::dim_t'(px);
    req.pub_y             = lbfit_pkg::dim_t'(py);
    req.pub_width         = lbfit_pkg::dim_t'(pw);
    req.pub_height        = lbfit_pkg::dim_t'(ph);
    req.pub_remote_width  = lbfit_pkg::dim_t'(prw);
    req.pub_remote_height = lbfit_pkg::dim_t'(prh);
    return req;
  endfunction

  // Sizes lean toward screen-like values but still reach zero, tiny values,
  // the top of the range and every bit pattern in between.
  function automatic lbfit_pkg::dim_t random_dim();
    case ($urandom_range(9))
      0:       return lbfit_pkg::dim_t'($urandom);
      1:       return lbfit_pkg::dim_t'(16'hFFFF - $urandom_range(3));
      2:       return lbfit_pkg::dim_t'($urandom_range(4));
      default: return lbfit_pkg::dim_t'($urandom_range(4096, 1));
    endcase
  endfunction

  // A size within spread pixels of base, kept inside the field's range.
  function automatic lbfit_pkg::dim_t near_dim(lbfit_pkg::dim_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return lbfit_pkg::dim_t'(v);
  endfunction

  function automatic lbfit_pkg::in_beat_t random_request();
    lbfit_pkg::in_beat_t req;
    int                  spread;
    req.target_width  = random_dim();
    req.target_height = random_dim();
    // A third of the frames sit close to the target so that the unscaled
    // path and its tolerance boundary are hit often.
    spread = int'(tolerance_now) + 2;
    if ($urandom_range(2) == 0) begin
      req.remote_width  = near_dim(req.target_width, spread);
      req.remote_height = near_dim(req.target_height, spread);
    end else begin
      req.remote_width  = random_dim();
      req.remote_height = random_dim();
    end
    req.pub_x             = lbfit_pkg::dim_t'($urandom);
    req.pub_y             = lbfit_pkg::dim_t'($urandom);
    req.pub_width         = lbfit_pkg::dim_t'($urandom);
    req.pub_height        = lbfit_pkg::dim_t'($urandom);
    req.pub_remote_width  = lbfit_pkg::dim_t'($urandom);
    req.pub_remote_height = lbfit_pkg::dim_t'($urandom);
    case ($urandom_range(3))
      0, 1: begin
        // A published rectangle made for this frame and lying in bounds,
        // sometimes knocked off by one in a single field.
        req.pub_remote_width  = req.remote_width;
        req.pub_remote_height = req.remote_height;
        if (req.target_width != 0) begin
          req.pub_width = lbfit_pkg::dim_t'($urandom_range(int'(req.target_width), 1));
          req.pub_x     = lbfit_pkg::dim_t'(
                            $urandom_range(int'(req.target_width - req.pub_width)));
        end
        if (req.target_height != 0) begin
          req.pub_height = lbfit_pkg::dim_t'($urandom_range(int'(req.target_height), 1));
          req.pub_y      = lbfit_pkg::dim_t'(
                             $urandom_range(int'(req.target_height - req.pub_height)));
        end
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(5))
            0:       req.pub_x             = req.pub_x + 1'b1;
            1:       req.pub_y             = req.pub_y + 1'b1;
            2:       req.pub_width         = req.pub_width + 1'b1;
            3:       req.pub_height        = req.pub_height + 1'b1;
            4:       req.pub_remote_width  = req.pub_remote_width + 1'b1;
            default: req.pub_remote_height = req.pub_remote_height + 1'b1;
          endcase
        end
      end
      2: begin
        // Leave the published fields fully random.
      end
      default: begin
        // No published rectangle: one of its sizes is zero.
        req.pub_remote_width  = req.remote_width;
        req.pub_remote_height = req.remote_height;
        if ($urandom_range(1) == 0) req.pub_width = '0;
        else req.pub_height = '0;
      end
    endcase
    return req;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      failed = 1'b1;
    end
  endtask

  // Offers one request beat, after a random idle gap, and holds it until it
  // is taken. The expected rectangle is queued at the accepting edge. The
  // task returns right after that edge with in_valid still high, so back to
  // back calls keep the channel busy without lowering valid, idle gaps apart.
  task automatic send_beat(lbfit_pkg::in_beat_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    expected_rects.push_back(fit_content_rect(req, tolerance_now));
  endtask

  // Closes a burst and waits until the block has delivered every rectangle.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rects.size() != 0) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(input bit write, input logic [lbfit_pkg::CFG_IDX_BITS-1:0] idx,
                            input logic [lbfit_pkg::CFG_DATA_BITS-1:0] wdata,
                            output logic [lbfit_pkg::CFG_DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (write && idx == lbfit_pkg::REG_TOLERANCE) begin
      tolerance_now = wdata[lbfit_pkg::TOL_BITS-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Registers change only with the pipeline empty. Every request yields a
  // result, so an empty queue means an empty block; the extra cycles cover
  // the pipeline depth anyway. The register is read back after the write.
  task automatic set_tolerance(logic [lbfit_pkg::TOL_BITS-1:0] value);
    logic [lbfit_pkg::CFG_DATA_BITS-1:0] rd;
    wait_for_results();
    repeat (lbfit_pkg::NUM_STAGES + 5) @(negedge clk);
    cfg_access(1'b1, lbfit_pkg::REG_TOLERANCE, lbfit_pkg::CFG_DATA_BITS'(value), rd);
    cfg_access(1'b0, lbfit_pkg::REG_TOLERANCE, '0, rd);
    report_mismatch("tolerance readback", 64'(tolerance_now), 64'(rd));
  endtask

  // Any dimension of zero gives an all-zero, invalid rectangle, even with a
  // published rectangle that would otherwise fit.
  task automatic test_zero_sizes();
    send_beat(make_request(0, 1080, 1280, 720, 0, 0, 100, 100, 1280, 720));
    send_beat(make_request(65535, 0, 65535, 65535, 0, 0, 65535, 65535, 65535, 65535));
    send_beat(make_request(1920, 1080, 0, 720, 0, 0, 100, 100, 0, 720));
    send_beat(make_request(1920, 1080, 1280, 0, 65535, 65535, 65535, 65535, 1280, 0));
  endtask

  // Equal sizes are shown unscaled even with zero tolerance, up to full range.
  task automatic test_one_to_one();
    send_beat(make_request(1280, 720, 1280, 720, 0, 0, 0, 0, 0, 0));
    send_beat(make_request(65535, 65535, 65535, 65535, 0, 0, 0, 0, 0, 0));
  endtask

  // Scaled fits: letterbox, pillarbox, downscale, and both clamps to one.
  task automatic test_aspect_fit();
    send_beat(make_request(1920, 1080, 1024, 768, 0, 0, 0, 0, 0, 0));
    send_beat(make_request(1024, 1080, 1920, 1080, 0, 0, 0, 0, 0, 0));
    send_beat(make_request(800, 600, 3840, 2160, 0, 0, 0, 0, 0, 0));
    send_beat(make_request(65535, 1, 1, 65535, 0, 0, 0, 0, 0, 0));
    send_beat(make_request(1, 65535, 65535, 1, 0, 0, 0, 0, 0, 0));
  endtask

  // The published rectangle is taken only when nonempty, made for this frame
  // and inside the target; the last two beats would pass if the edge sums
  // wrapped at 16 bits.
  task automatic test_published();
    send_beat(make_request(1920, 1080, 1280, 720, 100, 50, 800, 450, 1280, 720));
    send_beat(make_request(1920, 1080, 1280, 720, 100, 50, 0, 450, 1280, 720));
    send_beat(make_request(1920, 1080, 1280, 720, 100, 50, 800, 0, 1280, 720));
    send_beat(make_request(1920, 1080, 1280, 720, 100, 50, 800, 450, 1279, 720));
    send_beat(make_request(1920, 1080, 1280, 720, 100, 50, 800, 450, 1280, 721));
    send_beat(make_request(1920, 1080, 1280, 720, 1920, 50, 1, 450, 1280, 720));
    send_beat(make_request(1920, 1080, 1280, 720, 1121, 50, 800, 450, 1280, 720));
    send_beat(make_request(1920, 1080, 1280, 720, 1120, 630, 800, 450, 1280, 720));
    send_beat(make_request(65535, 65535, 65535, 65535, 1, 0, 65535, 10, 65535, 65535));
    send_beat(make_request(65535, 65535, 65535, 65535, 0, 2, 10, 65535, 65535, 65535));
  endtask

  // Checks the reset value, the tolerance boundary, a frame larger than the
  // target but within tolerance, a write to the unused index, and the top
  // tolerance.
  task automatic test_tolerance();
    logic [lbfit_pkg::CFG_DATA_BITS-1:0] rd;
    wait_for_results();
    cfg_access(1'b0, lbfit_pkg::REG_TOLERANCE, '0, rd);
    report_mismatch("tolerance after reset", 64'(tolerance_now), 64'(rd));
    set_tolerance(lbfit_pkg::TOL_BITS'(3));
    send_beat(make_request(1920, 1080, 1917, 1080, 0, 0, 0, 0, 0, 0));
    send_beat(make_request(1920, 1080, 1916, 1077, 0, 0, 0, 0, 0, 0));
    send_beat(make_request(1000, 1000, 1002, 1000, 0, 0, 0, 0, 0, 0));
    wait_for_results();
    cfg_access(1'b1, REG_SPARE, '1, rd);
    cfg_access(1'b0, lbfit_pkg::REG_TOLERANCE, '0, rd);
    report_mismatch("tolerance after unused write", 64'(tolerance_now), 64'(rd));
    set_tolerance(lbfit_pkg::TOL_BITS'(255));
    send_beat(make_request(500, 400, 300, 200, 0, 0, 0, 0, 0, 0));
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // every stage fills and in_stall must rise. Later the sender stops until
  // every rectangle has come back, then resumes.
  task automatic test_backpressure();
    set_tolerance(lbfit_pkg::TOL_BITS'(0));
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_left = 3 * lbfit_pkg::NUM_STAGES;
    repeat (2 * lbfit_pkg::NUM_STAGES + 10) send_beat(random_request());
    wait_for_results();
    repeat (20) send_beat(random_request());
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct,
                                     logic [lbfit_pkg::TOL_BITS-1:0] tol, int count);
    set_tolerance(tol);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    repeat (count) send_beat(random_request());
    wait_for_results();
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Receiver side: out_stall changes at the falling edge. A pending hold-off
  // is counted down here one cycle at a time; otherwise the stall is random.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Every rectangle the block hands over is matched against the oldest one
  // still owed. A rectangle nobody asked for is a failure too.
  always @(posedge clk) begin : check_rect
    lbfit_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rects.size() == 0) begin
        $display("%0t ns: unexpected rectangle beat, expected none, actual %h", $time,
                 out_data);
        failed = 1'b1;
      end else begin
        want = expected_rects.pop_front();
        report_mismatch("content_x", 64'(want.content_x), 64'(out_data.content_x));
        report_mismatch("content_y", 64'(want.content_y), 64'(out_data.content_y));
        report_mismatch("content_width", 64'(want.content_width),
                        64'(out_data.content_width));
        report_mismatch("content_height", 64'(want.content_height),
                        64'(out_data.content_height));
        report_mismatch("geometry_valid", 64'(want.geometry_valid),
                        64'(out_data.geometry_valid));
        report_mismatch("used_published", 64'(want.used_published),
                        64'(out_data.used_published));
      end
    end
  end

  // Main sequence: reset, directed cases, backpressure, then random traffic
  // under four idle patterns, each with its own tolerance setting.
  initial begin
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_zero_sizes();
    test_one_to_one();
    test_aspect_fit();
    test_published();
    test_tolerance();
    test_backpressure();
    test_random_traffic(0, 0, lbfit_pkg::TOL_BITS'(0), 250);
    test_random_traffic(50, 0, lbfit_pkg::TOL_BITS'(255), 250);
    test_random_traffic(0, 50, lbfit_pkg::TOL_BITS'($urandom_range(255)), 250);
    test_random_traffic(21, 21, lbfit_pkg::TOL_BITS'(17), 250);

    // Give a stray extra beat time to show up before deciding.
    wait_for_results();
    repeat (2 * lbfit_pkg::NUM_STAGES) @(negedge clk);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
